@@ hdl/hopa_pkg.sv @@
`default_nettype none
package hopa_pkg;

	localparam int MAX_CELLS    = 64;
	localparam int MAX_PATTERNS = 256;

	localparam int CELL_W  = $clog2(MAX_CELLS);
	localparam int ADDR_W  = 2 * CELL_W;
	localparam int DEPTH   = MAX_CELLS * MAX_CELLS;
	localparam int NCELL_W = 7;
	localparam int W_W     = 10;
	localparam int PC_W    = 9;
	localparam int PIX_W   = 8;
	localparam int REQ_W   = 2;
	localparam int IDX_W   = 6;

	localparam logic [REQ_W-1:0] REQ_SPIN  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	typedef struct packed {
		logic spin_start;
		logic clear;
		logic rd_start;
		logic spin_issue;
		logic rd_issue;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic spin_ok;
		logic j_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

@@ hdl/hopa_ifs.sv @@
`default_nettype none
interface hopa_req_if;
	import hopa_pkg::*;
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [PIX_W-1:0]  pixel;
	logic [IDX_W-1:0]  row;
	logic [IDX_W-1:0]  col;
	modport source (output valid, req_type, pixel, row, col, input ready);
	modport sink   (input valid, req_type, pixel, row, col, output ready);
endinterface

interface hopa_rsp_if;
	import hopa_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [W_W-1:0]  weight_count;
	logic [PC_W-1:0]        patterns_stored;
	modport source (output valid, weight_count, patterns_stored, input ready);
	modport sink   (input valid, weight_count, patterns_stored, output ready);
endinterface

interface hopa_cfg_if;
	import hopa_pkg::*;
	logic               valid;
	logic               ready;
	logic [NCELL_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hdl/hebbian_outer_product_accumulator_unit.sv @@
// channel | dir | transfer moves
// req     | in  | req_type, pixel, row, col
// rsp     | out | weight_count, patterns_stored (read requests only)
// cfg     | in  | cells_in_use write data
//
// A spin at cell i holds req while it is taken, then does one weight
// read-modify-write per cycle, j = 0..i, with read and write on separate ports.
// A read passes through ST_RD and ST_RD_DATA, waiting there on rsp; a clear is taken without leaving idle.
// Reset and clear act at once: per-row valid bits mark the weight memory empty.
// A result waiting on rsp still lets spins and clears through.
`default_nettype none
module hebbian_outer_product_accumulator_unit
	import hopa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	hopa_req_if.sink   req,
	hopa_rsp_if.source rsp,
	hopa_cfg_if.sink   cfg
);

	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	assign req.ready = in_ready;

	hopa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (in_ready),
		.status      (status),
		.cmd         (cmd)
	);

	hopa_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status)
	);

endmodule
`default_nettype wire

@@ hdl/hopa_ctrl.sv @@
`default_nettype none
module hopa_ctrl
	import hopa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [REQ_W-1:0] in_req_type,
	output logic                  in_ready,
	input  wire status_t          status,
	output cmd_t                  cmd
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SPIN    = 2'd1;
	localparam logic [1:0] ST_RD      = 2'd2;
	localparam logic [1:0] ST_RD_DATA = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (in_req_type)
						REQ_SPIN: begin
							if (status.spin_ok) begin
								cmd.spin_start = 1'b1;
								state_d        = ST_SPIN;
							end
						end
						REQ_CLEAR: cmd.clear = 1'b1;
						REQ_READ: begin
							cmd.rd_start = 1'b1;
							state_d      = ST_RD;
						end
						default: ;
					endcase
				end
			end
			ST_SPIN: begin
				cmd.spin_issue = 1'b1;
				if (status.j_last) state_d = ST_IDLE;
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

@@ hdl/hopa_datapath.sv @@
`default_nettype none
module hopa_datapath
	import hopa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	hopa_req_if.sink   req,
	hopa_rsp_if.source rsp,
	hopa_cfg_if.sink   cfg,
	input  wire cmd_t  cmd,
	output status_t    status
);

	localparam logic [NCELL_W-1:0] NMAX = NCELL_W'(MAX_CELLS);

	logic [NCELL_W-1:0]   cells_q;
	logic [NCELL_W-1:0]   n_act;
	logic [CELL_W-1:0]    cell_index_q;
	logic [PC_W:0]        pattern_count_q;
	logic [MAX_CELLS-1:0] spin_q;
	logic [MAX_CELLS-1:0] row_valid_q;

	logic [CELL_W-1:0]    i_q;
	logic [CELL_W-1:0]    j_q;
	logic                 si_q;
	logic                 rv_q;

	logic                 wr_s1;
	logic [CELL_W-1:0]    j_s1;
	logic                 match_s1;

	logic [ADDR_W-1:0]    addr_q;
	logic                 rd_ok_q;

	logic [W_W-1:0]       mem [DEPTH];
	logic [W_W-1:0]       rd_data_q;
	logic                 mem_re;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]    wr_addr;
	logic [W_W-1:0]       old_w;
	logic signed [W_W:0]  sum_w;
	logic [W_W-1:0]       new_w;

	logic                 out_valid_q;
	logic [W_W-1:0]       weight_q;
	logic [PC_W-1:0]      patterns_q;

	logic                 si_in;
	logic [CELL_W-1:0]    hi;
	logic [CELL_W-1:0]    lo;
	logic                 last_cell;

	assign cfg.ready = 1'b1;

	always_comb begin
		if (cells_q == '0) n_act = NCELL_W'(1);
		else if (cells_q > NMAX) n_act = NMAX;
		else n_act = cells_q;
	end

	assign si_in     = (req.pixel != '0);
	assign hi        = (req.row > req.col) ? req.row : req.col;
	assign lo        = (req.row > req.col) ? req.col : req.row;
	assign last_cell = (NCELL_W'(cell_index_q) + NCELL_W'(1)) >= n_act;

	assign status.spin_ok  = (pattern_count_q < (PC_W+1)'(MAX_PATTERNS));
	assign status.j_last   = (j_q == i_q);
	assign status.out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q         <= NCELL_W'(64);
			cell_index_q    <= '0;
			pattern_count_q <= '0;
			spin_q          <= '0;
			row_valid_q     <= '0;
			wr_s1           <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg.valid) cells_q <= cfg.data;
			wr_s1 <= cmd.spin_issue;
			if (cmd.clear) begin
				cell_index_q    <= '0;
				pattern_count_q <= '0;
				spin_q          <= '0;
				row_valid_q     <= '0;
			end else if (cmd.spin_start) begin
				spin_q[cell_index_q]      <= si_in;
				row_valid_q[cell_index_q] <= 1'b1;
				if (last_cell) begin
					cell_index_q    <= '0;
					pattern_count_q <= pattern_count_q + 1'b1;
				end else begin
					cell_index_q <= cell_index_q + 1'b1;
				end
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.spin_start) begin
			i_q  <= cell_index_q;
			si_q <= si_in;
			rv_q <= row_valid_q[cell_index_q];
			j_q  <= '0;
		end else if (cmd.spin_issue) begin
			j_q <= j_q + 1'b1;
		end
		if (cmd.spin_issue) begin
			j_s1     <= j_q;
			match_s1 <= (spin_q[j_q] == si_q);
		end
		if (cmd.rd_start) begin
			addr_q  <= {hi, lo};
			rd_ok_q <= (NCELL_W'(req.row) < n_act) && (NCELL_W'(req.col) < n_act)
				&& row_valid_q[hi];
		end
		if (cmd.out_load) begin
			weight_q   <= rd_ok_q ? rd_data_q : '0;
			patterns_q <= pattern_count_q[PC_W-1:0];
		end
	end

	assign mem_re  = cmd.spin_issue || cmd.rd_issue;
	assign rd_addr = cmd.spin_issue ? {i_q, j_q} : addr_q;
	assign wr_addr = {i_q, j_s1};
	assign old_w   = rv_q ? rd_data_q : '0;
	assign sum_w   = $signed({old_w[W_W-1], old_w}) + (match_s1 ? (W_W+1)'(1) : '1);

	always_comb begin
		if (sum_w > $signed((W_W+1)'(511))) new_w = W_W'(511);
		else if (sum_w < $signed(-(W_W+1)'(512))) new_w = W_W'(-512);
		else new_w = sum_w[W_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_s1) mem[wr_addr] <= new_w;
	end

	always_ff @(posedge clk) begin
		if (mem_re) rd_data_q <= mem[rd_addr];
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.weight_count    = $signed(weight_q);
	assign rsp.patterns_stored = patterns_q;

endmodule
`default_nettype wire

@@ test/hopa_weight_checker.sv @@
`timescale 1ns / 1ps
module hopa_weight_checker
	import hopa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	hopa_req_if  req,
	hopa_rsp_if  rsp,
	hopa_cfg_if  cfg,
	output int   mismatches,
	output int   reads_pending,
	output int   reads_checked
);

	localparam int COUNT_MAX = 2 ** (W_W - 1) - 1;
	localparam int COUNT_MIN = -(2 ** (W_W - 1));
	localparam int PC_MAX    = 2 ** PC_W - 1;

	typedef struct packed {
		logic signed [W_W-1:0] weight;
		logic [PC_W-1:0]       patterns;
	} read_result_t;

	logic                  spin_bits [MAX_CELLS];
	logic signed [W_W-1:0] weight_mem [DEPTH];
	int unsigned           cell_idx;
	int unsigned           pattern_total;
	logic [NCELL_W-1:0]    cells_reg;
	read_result_t          expected_reads [$];
	read_result_t          want;

	initial begin
		mismatches    = 0;
		reads_pending = 0;
		reads_checked = 0;
	end

	function automatic int unsigned cells_active();
		if (cells_reg == 0)
			return 1;
		if (cells_reg > MAX_CELLS)
			return MAX_CELLS;
		return cells_reg;
	endfunction

	function automatic void wipe_store();
		foreach (spin_bits[k])
			spin_bits[k] = 1'b0;
		foreach (weight_mem[k])
			weight_mem[k] = '0;
		cell_idx      = 0;
		pattern_total = 0;
	endfunction

	function automatic void take_spin(input logic [PIX_W-1:0] pixel);
		int unsigned n;
		int unsigned i;
		int unsigned j;
		logic        s;
		int          w;
		n = cells_active();
		i = cell_idx;
		s = (pixel != '0);
		if (pattern_total >= MAX_PATTERNS)
			return;
		if (i >= MAX_CELLS)
			i = MAX_CELLS - 1;
		spin_bits[i] = s;
		for (j = 0; j <= i; j++) begin
			w = weight_mem[i * MAX_CELLS + j];
			w = w + ((spin_bits[j] == s) ? 1 : -1);
			if (w > COUNT_MAX)
				w = COUNT_MAX;
			if (w < COUNT_MIN)
				w = COUNT_MIN;
			weight_mem[i * MAX_CELLS + j] = w[W_W-1:0];
		end
		if (i + 1 >= n) begin
			cell_idx = 0;
			pattern_total++;
		end else begin
			cell_idx = i + 1;
		end
	endfunction

	function automatic read_result_t weight_at(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		read_result_t res;
		int unsigned  n;
		int unsigned  hi;
		int unsigned  lo;
		n = cells_active();
		res.weight = '0;
		if (r < n && c < n) begin
			hi = (r > c) ? r : c;
			lo = (r > c) ? c : r;
			res.weight = weight_mem[hi * MAX_CELLS + lo];
		end
		res.patterns = PC_W'((pattern_total > PC_MAX) ? PC_MAX : pattern_total);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_store();
			cells_reg = NCELL_W'(MAX_CELLS);
			expected_reads.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				cells_reg = cfg.data;
			if (req.valid && req.ready) begin
				case (req.req_type)
				REQ_SPIN: take_spin(req.pixel);
				REQ_CLEAR: wipe_store();
				REQ_READ: expected_reads.push_back(weight_at(req.row, req.col));
				default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_reads.size() == 0) begin
					$error("unexpected result: weight_count %0d, patterns_stored %0d",
						rsp.weight_count, rsp.patterns_stored);
					mismatches++;
				end else begin
					want = expected_reads.pop_front();
					reads_checked++;
					if (rsp.weight_count !== want.weight) begin
						$error("weight_count: expected %0d, actual %0d",
							want.weight, rsp.weight_count);
						mismatches++;
					end
					if (rsp.patterns_stored !== want.patterns) begin
						$error("patterns_stored: expected %0d, actual %0d",
							want.patterns, rsp.patterns_stored);
						mismatches++;
					end
				end
			end
		end
		reads_pending = expected_reads.size();
	end

endmodule

@@ test/hebbian_outer_product_accumulator_unit_test.sv @@
`timescale 1ns / 1ps
module hebbian_outer_product_accumulator_unit_test;
	import hopa_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES  = 80;
	localparam int WATCHDOG_LIMIT = 1000;

	logic        clk;
	logic        arst_n;
	int          mismatches;
	int          reads_pending;
	int          reads_checked;
	int          idle_cycles = 0;
	int unsigned cells_eff   = MAX_CELLS;
	int          spins_sent  = 0;
	int          reads_sent  = 0;
	int          clears_sent = 0;
	int          unused_sent = 0;
	int          cfg_writes  = 0;
	bit          req_burst   = 1'b0;
	bit          rsp_burst   = 1'b0;

	hopa_req_if req_ch();
	hopa_rsp_if rsp_ch();
	hopa_cfg_if cfg_ch();

	hebbian_outer_product_accumulator_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	hopa_weight_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.cfg           (cfg_ch),
		.mismatches    (mismatches),
		.reads_pending (reads_pending),
		.reads_checked (reads_checked)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) === 1'b1 ||
				(rsp_ch.valid && rsp_ch.ready) === 1'b1 ||
				(cfg_ch.valid && cfg_ch.ready) === 1'b1) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rsp_burst = !rsp_burst;
			stall = rsp_burst ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while ((rsp_ch.valid && rsp_ch.ready) !== 1'b1);
		end
	end

	task automatic send_req(input logic [REQ_W-1:0] kind, input logic [PIX_W-1:0] pix,
			input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
		int gap;
		if ($urandom_range(0, 15) == 0)
			req_burst = !req_burst;
		gap = req_burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.pixel    <= pix;
		req_ch.row      <= r;
		req_ch.col      <= c;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		case (kind)
		REQ_SPIN: spins_sent++;
		REQ_CLEAR: clears_sent++;
		REQ_READ: reads_sent++;
		default: unused_sent++;
		endcase
	endtask

	// drop valid, wait out pending reads and any spin still in flight
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (reads_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cells(input logic [NCELL_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		cells_eff = (value == 0) ? 1 : (value > MAX_CELLS) ? MAX_CELLS : value;
		cfg_writes++;
	endtask

	task automatic random_items(input int count, input int clear_pct, input int spin_pct);
		int unsigned      roll;
		logic [REQ_W-1:0] kind;
		logic [PIX_W-1:0] pix;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			pix  = ($urandom_range(0, 2) == 0) ? '0 : PIX_W'($urandom);
			r    = IDX_W'($urandom);
			c    = IDX_W'($urandom);
			if ($urandom_range(0, 3) != 0) begin
				r = IDX_W'($urandom_range(0, cells_eff - 1));
				c = IDX_W'($urandom_range(0, cells_eff - 1));
			end
			if (roll < clear_pct)
				kind = REQ_CLEAR;
			else if (roll < clear_pct + 2)
				kind = REQ_UNUSED;
			else if (roll < spin_pct)
				kind = REQ_SPIN;
			else
				kind = REQ_READ;
			send_req(kind, pix, r, c);
		end
	endtask

	task automatic run_phase(input logic [NCELL_W-1:0] setting, input int count,
			input int clear_pct, input int spin_pct);
		settle();
		write_cells(setting);
		send_req(REQ_CLEAR, PIX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
		random_items(count, clear_pct, spin_pct);
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_SPIN;
		req_ch.pixel    = '0;
		req_ch.row      = '0;
		req_ch.col      = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_cells(7'd3);
		send_req(REQ_READ, 8'h00, 6'd0, 6'd0);
		send_req(REQ_SPIN, 8'h00, 6'd0, 6'd0);
		send_req(REQ_SPIN, 8'hff, 6'd0, 6'd0);
		send_req(REQ_SPIN, 8'h01, 6'd0, 6'd0);
		send_req(REQ_READ, 8'h00, 6'd2, 6'd0);
		send_req(REQ_READ, 8'h00, 6'd0, 6'd2);
		send_req(REQ_READ, 8'h00, 6'd1, 6'd1);
		send_req(REQ_READ, 8'h00, 6'd3, 6'd3);
		send_req(REQ_READ, 8'hff, 6'd63, 6'd63);
		send_req(REQ_UNUSED, 8'hff, 6'd63, 6'd63);
		send_req(REQ_SPIN, 8'h80, 6'd0, 6'd0);
		send_req(REQ_SPIN, 8'h7f, 6'd0, 6'd0);
		settle();
		// lower the cell count in mid-pattern: next spin closes the pattern
		write_cells(7'd1);
		send_req(REQ_SPIN, 8'h00, 6'd0, 6'd0);
		send_req(REQ_READ, 8'h00, 6'd2, 6'd2);
		send_req(REQ_READ, 8'h00, 6'd0, 6'd0);
		settle();
		write_cells(7'd0);
		send_req(REQ_SPIN, 8'h01, 6'd0, 6'd0);
		send_req(REQ_READ, 8'h00, 6'd0, 6'd0);
		send_req(REQ_READ, 8'h00, 6'd0, 6'd1);
		settle();
		write_cells(7'd127);
		send_req(REQ_READ, 8'h00, 6'd63, 6'd63);
		send_req(REQ_READ, 8'h00, 6'd2, 6'd1);
		send_req(REQ_CLEAR, 8'h00, 6'd0, 6'd0);
		send_req(REQ_READ, 8'h00, 6'd0, 6'd0);

		run_phase(7'd64, 80, 1, 70);
		// single-cell patterns: fill the store and run past it
		run_phase(7'd1, 330, 0, 90);
		run_phase(7'd2, 45, 2, 70);
		run_phase(7'd127, 45, 1, 75);
		run_phase(7'd0, 45, 2, 65);
		run_phase(7'd7, 45, 2, 70);
		run_phase(7'd40, 45, 1, 75);
		run_phase(NCELL_W'($urandom_range(1, MAX_CELLS)), 45, 2, 70);
		settle();

		$display("Covered %0d spins, %0d weight reads, %0d clears, %0d unused requests;",
			spins_sent, reads_sent, clears_sent, unused_sent);
		$display("%0d results compared over %0d cell-count settings incl. 0, 1, 64, 127.",
			reads_checked, cfg_writes);
		if (mismatches == 0 && reads_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
